// ----- rtl/sspm_pkg.sv -----
// Shared types, constants and modular helpers of the sparse series multiply/divide core.
// No dependencies; every module of the core imports this package.
package sspm_pkg;

   localparam int RES_W      = 30;
   localparam int LAG_W      = 11;
   localparam int TAP_W      = LAG_W + RES_W;
   localparam int CSR_ADDR_W = 4;

   localparam logic [RES_W-1:0] MODULUS = RES_W'(998244353);

   // Barrett constant floor(2^60 / MODULUS), settled at elaboration.
   localparam logic [63:0] MU_FULL    = (64'd1 << 60) / 64'd998244353;
   localparam logic [30:0] BARRETT_MU = MU_FULL[30:0];

   // Register indexes of the configuration port.
   localparam logic [CSR_ADDR_W-1:0] CSR_MODE = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_LEAD = CSR_ADDR_W'(1);
   localparam logic [CSR_ADDR_W-1:0] CSR_TAP0 = CSR_ADDR_W'(2);

   typedef struct packed {
      logic [LAG_W-1:0] lag;
      logic [RES_W-1:0] coef;
   } tap_type;

   typedef struct packed {
      logic             valid;
      logic [RES_W-1:0] a;
      logic [RES_W-1:0] b;
   } mm_req_type;

   typedef struct packed {
      logic             valid;
      logic             busy;
      logic [RES_W-1:0] value;
   } mm_rsp_type;

   // Brings a 30-bit value below the modulus; 2^30 is less than twice the modulus.
   function automatic logic [RES_W-1:0] mod_fold(input logic [RES_W-1:0] v);
      return (v >= MODULUS) ? v - MODULUS : v;
   endfunction

   function automatic logic [RES_W-1:0] mod_add(input logic [RES_W-1:0] a,
                                                input logic [RES_W-1:0] b);
      logic [RES_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, MODULUS}) begin
         s = s - {1'b0, MODULUS};
      end
      return s[RES_W-1:0];
   endfunction

   function automatic logic [RES_W-1:0] mod_sub(input logic [RES_W-1:0] a,
                                                input logic [RES_W-1:0] b);
      logic [RES_W-1:0] d;
      if (a >= b) begin
         d = a - b;
      end else begin
         d = a + (MODULUS - b);
      end
      return d;
   endfunction

endpackage

// ----- rtl/sspm_mulmod.sv -----
// Five-stage pipelined modular multiplier (Barrett reduction modulo 998244353).
// Depends on sspm_pkg for the modulus, the Barrett constant and the request types.
module sspm_mulmod (
   input  logic                clock,
   input  logic                reset,
   input  sspm_pkg::mm_req_type req,
   output sspm_pkg::mm_rsp_type rsp
);
   import sspm_pkg::*;

   localparam logic [31:0] MOD_32  = {2'b00, MODULUS};
   localparam logic [31:0] MOD2_32 = {1'b0, MODULUS, 1'b0};

   logic [4:0]  vld_ff, vld_in;
   logic [59:0] prod1_ff, prod1_in;
   logic [61:0] q2_ff, q2_in;
   logic [31:0] plow2_ff, plow2_in;
   logic [31:0] t3_ff, t3_in;
   logic [31:0] plow3_ff, plow3_in;
   logic [31:0] r4_ff, r4_in;
   logic [RES_W-1:0] y5_ff, y5_in;
   logic [60:0] qp;
   logic [31:0] fold;

   always_comb begin
      vld_in   = {vld_ff[3:0], req.valid};
      prod1_in = 60'(req.a) * 60'(req.b);
      q2_in    = 62'(prod1_ff[59:29]) * 62'(BARRETT_MU);
      plow2_in = prod1_ff[31:0];
      qp       = 61'(q2_ff[61:31]) * 61'(MODULUS);
      t3_in    = qp[31:0];
      plow3_in = plow2_ff;
      // The estimate leaves a remainder below three times the modulus.
      r4_in    = plow3_ff - t3_ff;
      if (r4_ff >= MOD2_32) begin
         fold = r4_ff - MOD2_32;
      end else if (r4_ff >= MOD_32) begin
         fold = r4_ff - MOD_32;
      end else begin
         fold = r4_ff;
      end
      y5_in = fold[RES_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      prod1_ff <= prod1_in;
      q2_ff    <= q2_in;
      plow2_ff <= plow2_in;
      t3_ff    <= t3_in;
      plow3_ff <= plow3_in;
      r4_ff    <= r4_in;
      y5_ff    <= y5_in;
   end

   assign rsp.valid = vld_ff[4];
   assign rsp.busy  = |vld_ff;
   assign rsp.value = y5_ff;

endmodule

// ----- rtl/sspm_hist_ram.sv -----
// History RAM of the core: one write port and one registered read port.
// Depends on sspm_pkg for the word width.
module sspm_hist_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [sspm_pkg::RES_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [sspm_pkg::RES_W-1:0] rd_data
);
   import sspm_pkg::*;

   logic [RES_W-1:0] mem [DEPTH];
   logic [RES_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sparse_series_mul_div_mod_core.sv -----
// Sparse power-series multiply/divide modulo 998244353, one word in flight at a time.
// Taps are read from the history RAM one per cycle and pass through the five-stage shared
// modular multiplier; divide mode adds a further pass through it. The next word is taken
// the cycle after the result register loads. Synchronous active-high reset clears control
// state and loads mode 0, lead_scale 1 and zero taps; the history RAM is not cleared.
module sparse_series_mul_div_mod_core #(
   parameter int MAX_LAG = 1024,
   parameter int TAPS    = 6
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [sspm_pkg::RES_W-1:0]      req_coefficient,
   input  logic                           req_first,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [sspm_pkg::RES_W-1:0]      rsp_result,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sspm_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [sspm_pkg::TAP_W-1:0]      csr_wdata
);
   import sspm_pkg::*;

   localparam int PTR_W     = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
   localparam int IDX_W     = $clog2(MAX_LAG + 1);
   localparam int CMP_W     = ((IDX_W > LAG_W) ? IDX_W : LAG_W) + 1;
   localparam int TAP_IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int CNT_W     = $clog2(TAPS + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_TAPS   = 3'd1;
   localparam logic [2:0] ST_DRAIN  = 3'd2;
   localparam logic [2:0] ST_LEAD   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   // Configuration registers. Coefficients are stored already folded below the modulus.
   logic             mode_ff, mode_in;
   logic [RES_W-1:0] lead_ff, lead_in;
   tap_type          tap_ff [TAPS];
   tap_type          tap_in [TAPS];

   // Sequencer and datapath registers.
   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [RES_W-1:0] acc_ff, acc_in;
   logic [RES_W-1:0] x_ff, x_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic             lead_done_ff, lead_done_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [RES_W-1:0] pend_coef_ff, pend_coef_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RES_W-1:0] rsp_result_ff, rsp_result_in;

   // Current tap lookup and the history slot that it reaches back to.
   tap_type          cur_tap;
   logic [CMP_W-1:0] lag_ext;
   logic [CMP_W-1:0] wp_ext;
   logic [CMP_W-1:0] slot_ext;
   logic             cur_valid;
   logic             in_tap_range;

   logic             ram_wr_en;
   logic [PTR_W-1:0] ram_wr_addr;
   logic [RES_W-1:0] ram_wr_data;
   logic             ram_rd_en;
   logic [PTR_W-1:0] ram_rd_addr;
   logic [RES_W-1:0] ram_rd_data;

   mm_req_type       mm_req;
   mm_rsp_type       mm_rsp;

   logic             accept;
   logic             deliver;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

   // Configuration writes. An index beyond the list writes nothing.
   always_comb begin
      mode_in = mode_ff;
      lead_in = lead_ff;
      tap_in  = tap_ff;
      if (csr_valid && csr_ready) begin
         if (csr_addr == CSR_MODE) begin
            mode_in = csr_wdata[0];
         end
         if (csr_addr == CSR_LEAD) begin
            lead_in = mod_fold(csr_wdata[RES_W-1:0]);
         end
         for (int k = 0; k < TAPS; k++) begin
            if (csr_addr == CSR_ADDR_W'(CSR_TAP0 + k)) begin
               tap_in[k].lag  = csr_wdata[TAP_W-1:RES_W];
               tap_in[k].coef = mod_fold(csr_wdata[RES_W-1:0]);
            end
         end
      end
   end

   // A tap counts only when its coefficient is nonzero and its lag lies in 1..MAX_LAG
   // and does not reach past the start of the current series.
   assign in_tap_range = (cnt_ff < CNT_W'(TAPS));
   assign cur_tap      = tap_ff[cnt_ff[TAP_IDX_W-1:0]];
   assign lag_ext      = CMP_W'(cur_tap.lag);
   assign wp_ext       = CMP_W'(wp_ff);
   assign cur_valid    = in_tap_range && (cur_tap.coef != '0) && (cur_tap.lag != '0) &&
                         (lag_ext <= CMP_W'(MAX_LAG)) && (lag_ext <= CMP_W'(idx_ff));

   // The ring wraps at MAX_LAG, which need not be a power of two.
   always_comb begin
      if (wp_ext >= lag_ext) begin
         slot_ext = wp_ext - lag_ext;
      end else begin
         slot_ext = wp_ext + CMP_W'(MAX_LAG) - lag_ext;
      end
   end

   assign ram_rd_addr = slot_ext[PTR_W-1:0];

   // Sequencer. In the tap phase one tap is looked up per cycle; its history word
   // comes out of the registered RAM read in the next cycle and goes to the shared multiplier
   // with the coefficient held alongside. Products are summed into the accumulator as they leave the
   // multiplier. Divide mode then sends (x - sum) times lead_scale through the same unit.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      acc_in        = acc_ff;
      x_in          = x_ff;
      idx_in        = idx_ff;
      wp_in         = wp_ff;
      lead_done_in  = lead_done_ff;
      pend_valid_in = 1'b0;
      pend_coef_in  = cur_tap.coef;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_result_in = rsp_result_ff;
      ram_rd_en     = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = wp_ff;
      ram_wr_data   = mode_ff ? acc_ff : x_ff;
      mm_req.valid  = 1'b0;
      mm_req.a      = pend_coef_ff;
      mm_req.b      = ram_rd_data;
      deliver       = 1'b0;

      if (mm_rsp.valid) begin
         acc_in = mod_add(acc_ff, mm_rsp.value);
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x_in         = mod_fold(req_coefficient);
               acc_in       = '0;
               cnt_in       = '0;
               lead_done_in = 1'b0;
               if (req_first) begin
                  idx_in = '0;
               end
               state_in = ST_TAPS;
            end
         end
         ST_TAPS: begin
            ram_rd_en     = in_tap_range;
            pend_valid_in = cur_valid;
            if (cnt_ff == '0) begin
               // The lead term of a product needs no history and takes the first slot.
               mm_req.valid = !mode_ff;
               mm_req.a     = lead_ff;
               mm_req.b     = x_ff;
            end else begin
               mm_req.valid = pend_valid_ff;
            end
            if (cnt_ff == CNT_W'(TAPS)) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!mm_rsp.busy) begin
               if (!mode_ff || lead_done_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_LEAD;
               end
            end
         end
         ST_LEAD: begin
            // The accumulator restarts and collects the single scaled result.
            mm_req.valid = 1'b1;
            mm_req.a     = mod_sub(x_ff, acc_ff);
            mm_req.b     = lead_ff;
            acc_in       = '0;
            lead_done_in = 1'b1;
            state_in     = ST_DRAIN;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               deliver       = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_result_in = acc_ff;
               ram_wr_en     = 1'b1;
               if (wp_ff == PTR_W'(MAX_LAG - 1)) begin
                  wp_in = '0;
               end else begin
                  wp_in = wp_ff + PTR_W'(1);
               end
               if (idx_ff != IDX_W'(MAX_LAG)) begin
                  idx_in = idx_ff + IDX_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= 1'b0;
         lead_ff       <= RES_W'(1);
         for (int k = 0; k < TAPS; k++) begin
            tap_ff[k] <= '0;
         end
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         idx_ff        <= '0;
         wp_ff         <= '0;
         lead_done_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         lead_ff       <= lead_in;
         tap_ff        <= tap_in;
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         idx_ff        <= idx_in;
         wp_ff         <= wp_in;
         lead_done_ff  <= lead_done_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      acc_ff        <= acc_in;
      x_ff          <= x_in;
      pend_coef_ff  <= pend_coef_in;
      rsp_result_ff <= rsp_result_in;
   end

   sspm_hist_ram #(
      .DEPTH  (MAX_LAG),
      .ADDR_W (PTR_W)
   ) u_hist (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   sspm_mulmod u_mulmod (
      .clock (clock),
      .reset (reset),
      .req   (mm_req),
      .rsp   (mm_rsp)
   );

   // A new word is only taken once the multiplier has no products left in flight.
   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !mm_rsp.busy)
      else $error("input ready while the multiplier still holds products");

   // An accepted word always starts the tap phase on the next cycle.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_TAPS))
      else $error("accepted word did not start the tap phase");

   // The sum handed to the result register is a proper residue.
   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      deliver |-> (acc_ff < MODULUS))
      else $error("result word not reduced below the modulus");

   // A result word appears only out of the finish step.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result valid raised outside the finish step");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the sparse power-series multiply/divide core (mod 998244353).
// Depends on rtl/sspm_pkg.sv, rtl/sparse_series_mul_div_mod_core.sv and its submodules.
`timescale 1ns / 1ps

module tb_top;
   import sspm_pkg::*;

   localparam int MAX_LAG = 1024;
   localparam int TAPS    = 6;

   // Drain allowance after the last result; it grows with the number of taps.
   localparam int DRAIN_CYCLES  = 2 * (TAPS + 16);
   localparam int HOLD_CYCLES   = 400;
   localparam int QUIET_LIMIT   = 4000;
   localparam int LONG_LEN      = 120;
   localparam int RANDOM_PHASES = 8;

   localparam logic MODE_MUL = 1'b0;
   localparam logic MODE_DIV = 1'b1;

   // An index that selects no register; a write there must change nothing.
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE = CSR_ADDR_W'(15);

   localparam int unsigned MOD_U    = MODULUS;
   localparam int unsigned RES_TOP  = (1 << RES_W) - 1;
   localparam int unsigned LAG_TOP  = (1 << LAG_W) - 1;
   localparam longint unsigned MOD64 = MODULUS;

   typedef struct packed {
      logic [RES_W-1:0] coefficient;
      logic             first;
   } series_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [RES_W-1:0]      req_coefficient = '0;
   logic                  req_first = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [RES_W-1:0]      rsp_result;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [TAP_W-1:0]      csr_wdata = '0;

   sparse_series_mul_div_mod_core #(
      .MAX_LAG (MAX_LAG),
      .TAPS    (TAPS)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_coefficient (req_coefficient),
      .req_first       (req_first),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result      (rsp_result),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow copy of the core: configuration, history ring and the index
   // within the current series. Updated on the edges that accept input words and writes.
   // ------------------------------------------------------------------
   logic             shadow_mode = MODE_MUL;
   logic [RES_W-1:0] shadow_lead = RES_W'(1);
   tap_type          shadow_taps [TAPS];
   logic [RES_W-1:0] shadow_history [MAX_LAG];
   int               shadow_slot = 0;
   int               shadow_index = 0;

   initial begin
      for (int k = 0; k < TAPS; k++) begin
         shadow_taps[k] = '0;
      end
   end

   // Mirrors one register write; indexes outside the register map are ignored.
   function automatic void shadow_csr_write(input logic [CSR_ADDR_W-1:0] addr,
                                            input logic [TAP_W-1:0] data);
      if (addr == CSR_MODE) begin
         shadow_mode = data[0];
      end else if (addr == CSR_LEAD) begin
         shadow_lead = data[RES_W-1:0];
      end else if (addr >= CSR_TAP0 && int'(addr) < int'(CSR_TAP0) + TAPS) begin
         shadow_taps[int'(addr) - int'(CSR_TAP0)] = data;
      end
   endfunction

   // Computes the output coefficient for one input word and advances the
   // history ring. In multiply mode the ring holds inputs (FIR), in divide
   // mode it holds outputs (IIR).
   function automatic logic [RES_W-1:0] series_coefficient(input logic [RES_W-1:0] coefficient,
                                                           input logic first);
      longint unsigned x;
      longint unsigned lead;
      longint unsigned acc;
      longint unsigned c;
      longint unsigned h;
      longint unsigned out_value;
      int              lag;
      int              slot;
      x    = coefficient;
      x    = x % MOD64;
      lead = shadow_lead;
      lead = lead % MOD64;
      acc  = 0;
      if (first) begin
         shadow_index = 0;
      end
      for (int k = 0; k < TAPS; k++) begin
         lag = shadow_taps[k].lag;
         c   = shadow_taps[k].coef;
         c   = c % MOD64;
         // A tap only counts when its coefficient and lag are live and it does
         // not reach back past the start of the series.
         if (c != 0 && lag != 0 && lag <= MAX_LAG && lag <= shadow_index) begin
            slot = (shadow_slot + MAX_LAG - lag) % MAX_LAG;
            h    = shadow_history[slot];
            acc  = (acc + c * h) % MOD64;
         end
      end
      if (shadow_mode == MODE_MUL) begin
         out_value = (lead * x + acc) % MOD64;
         shadow_history[shadow_slot] = x[RES_W-1:0];
      end else begin
         out_value = (((x + MOD64 - acc) % MOD64) * lead) % MOD64;
         shadow_history[shadow_slot] = out_value[RES_W-1:0];
      end
      shadow_slot = (shadow_slot + 1) % MAX_LAG;
      if (shadow_index < MAX_LAG) begin
         shadow_index++;
      end
      return out_value[RES_W-1:0];
   endfunction

   // ------------------------------------------------------------------
   // Shared bench state.
   // ------------------------------------------------------------------
   series_word_type  pending_words [$];
   logic [RES_W-1:0] expected_results [$];
   series_word_type  next_word;
   logic [RES_W-1:0] want_result;
   bit               idle_on = 1'b1;
   bit               hold_armed = 1'b0;
   bit               hold_done = 1'b0;
   int               hold_left = 0;
   int               send_gap = 0;
   int               rsp_stall = 0;
   int               quiet_cycles = 0;
   int               words_sent = 0;
   int               results_checked = 0;
   int               csr_writes = 0;
   int               settings_used = 0;
   int               failures = 0;

   // Mostly back-to-back, sometimes a few cycles, now and then a long pause.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 60) begin
         return 0;
      end else if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Input driver: one word on the bus at a time, refilled from the queue.
   // The expected output is worked out at the edge that takes the word.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(series_coefficient(req_coefficient, req_first));
            words_sent++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               next_word = pending_words.pop_front();
               req_valid       <= 1'b1;
               req_coefficient <= next_word.coefficient;
               req_first       <= next_word.first;
               send_gap = pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Output monitor: checks each accepted word against the oldest prediction
   // and throttles rsp_ready. Once armed, it holds ready low for a long stretch
   // so the core backs up and stalls its input side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("result word %0d arrived with no input word pending", rsp_result);
               failures++;
            end else begin
               want_result = expected_results.pop_front();
               results_checked++;
               if (rsp_result !== want_result) begin
                  $error("result mismatch: expected %0d, actual %0d",
                         want_result, rsp_result);
                  failures++;
               end
            end
         end
         if (hold_armed && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            rsp_stall = pick_gap();
         end
      end
   end

   // The shadow configuration follows register writes on the accepting edge.
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         shadow_csr_write(csr_addr, csr_wdata);
      end
   end

   // Watchdog: a long run of cycles with no word moving on any channel means
   // the core has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $error("no word moved for %0d cycles; %0d results still outstanding",
                   QUIET_LIMIT, expected_results.size());
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [TAP_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
      csr_writes++;
   endtask

   task automatic write_tap(input int k, input int unsigned lag, input logic [RES_W-1:0] coef);
      tap_type t;
      t.lag  = LAG_W'(lag);
      t.coef = coef;
      write_csr(CSR_ADDR_W'(int'(CSR_TAP0) + k), t);
   endtask

   // Mode and lead scale carry random junk in the unused upper bits.
   task automatic write_mode(input logic mode_bit);
      logic [63:0] junk;
      junk = {$urandom(), $urandom()};
      write_csr(CSR_MODE, {junk[TAP_W-1:1], mode_bit});
   endtask

   task automatic write_lead(input logic [RES_W-1:0] lead);
      logic [31:0] junk;
      junk = $urandom();
      write_csr(CSR_LEAD, {junk[LAG_W-1:0], lead});
   endtask

   task automatic add_word(input int unsigned coefficient, input logic first);
      series_word_type w;
      w.coefficient = RES_W'(coefficient);
      w.first       = first;
      pending_words.push_back(w);
   endtask

   // Blocks until every queued word has gone in and come back, then lets
   // the pipeline drain before anything touches the registers.
   task automatic wait_idle();
      @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic int unsigned rand_residue();
      return $urandom_range(0, MOD_U - 1);
   endfunction

   // Mostly proper residues, with some at or above the modulus.
   function automatic int unsigned rand_coefficient();
      int r;
      r = $urandom_range(0, 99);
      if (r < 6) begin
         return $urandom_range(MOD_U, RES_TOP);
      end else if (r < 8) begin
         return 0;
      end else if (r < 10) begin
         return MOD_U - 1;
      end
      return rand_residue();
   endfunction

   function automatic int unsigned rand_lead();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) begin
         return 0;
      end else if (r < 16) begin
         return MOD_U - 1;
      end else if (r < 26) begin
         return $urandom_range(MOD_U, RES_TOP);
      end
      return $urandom_range(1, MOD_U - 1);
   endfunction

   // Short lags dominate so taps land inside short series; the rest are dead
   // lags (zero or past the history) and long ones.
   function automatic int unsigned rand_lag();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return $urandom_range(1, 24);
      end else if (r < 70) begin
         return 0;
      end else if (r < 80) begin
         return $urandom_range(MAX_LAG + 1, LAG_TOP);
      end else if (r < 90) begin
         return $urandom_range(25, MAX_LAG);
      end
      return $urandom_range(1, 3);
   endfunction

   function automatic int unsigned rand_tap_coef();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         return 0;
      end else if (r < 20) begin
         return $urandom_range(MOD_U, RES_TOP);
      end
      return $urandom_range(1, MOD_U - 1);
   endfunction

   task automatic random_settings();
      write_mode($urandom_range(0, 1) ? MODE_DIV : MODE_MUL);
      write_lead(RES_W'(rand_lead()));
      for (int k = 0; k < TAPS; k++) begin
         write_tap(k, rand_lag(), RES_W'(rand_tap_coef()));
      end
      settings_used++;
   endtask

   // A handful of series with random content. The first one sometimes lacks
   // its start mark, so it carries on from whatever came before.
   task automatic random_phase();
      int series_count;
      int len;
      series_count = $urandom_range(1, 3);
      for (int s = 0; s < series_count; s++) begin
         len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 30) : $urandom_range(31, 60);
         for (int i = 0; i < len; i++) begin
            add_word(rand_coefficient(),
                     (i == 0) ? !(s == 0 && $urandom_range(0, 99) < 20) : 1'b0);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset settings make the core an identity; push the coefficient
      // extremes, including values at and above the modulus.
      add_word(0, 1'b1);
      add_word(MOD_U - 1, 1'b0);
      add_word(MOD_U, 1'b0);
      add_word(RES_TOP, 1'b0);
      wait_idle();

      // A write to an unmapped index must not disturb anything.
      write_csr(CSR_SPARE, '1);

      // Multiply with every kind of odd tap: unsorted and repeated lags, an
      // over-range coefficient, a zero lag, a zero coefficient and a lag
      // beyond the history.
      write_csr(CSR_MODE, {{(TAP_W - 1){1'b1}}, MODE_MUL});
      write_lead(RES_W'(MOD_U - 1));
      write_tap(0, 2, RES_W'(5));
      write_tap(1, 1, RES_W'(MOD_U - 1));
      write_tap(2, 2, RES_W'(RES_TOP));
      write_tap(3, 0, RES_W'(7));
      write_tap(4, 3, RES_W'(0));
      write_tap(5, LAG_TOP, RES_W'(9));
      settings_used++;
      add_word(RES_TOP, 1'b1);
      add_word(MOD_U - 1, 1'b0);
      add_word(0, 1'b0);
      add_word(1, 1'b0);
      add_word(MOD_U - 1, 1'b0);
      add_word(MOD_U, 1'b0);
      wait_idle();

      // Switch to divide in the middle of that series with no start mark;
      // the lead scale is above the modulus and gets reduced.
      write_mode(MODE_DIV);
      write_lead(RES_W'(RES_TOP));
      settings_used++;
      add_word(MOD_U - 1, 1'b0);
      add_word(12345, 1'b0);
      add_word(0, 1'b0);
      add_word(MOD_U - 1, 1'b1);
      add_word(1, 1'b0);
      add_word(2, 1'b0);
      add_word(RES_TOP, 1'b0);
      wait_idle();

      // Divide with a zero lead scale yields zeros.
      write_lead('0);
      settings_used++;
      add_word(77, 1'b1);
      add_word(5, 1'b0);
      wait_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         idle_on = (p % 3 != 1);
         random_settings();
         random_phase();
         wait_idle();

         if (p == RANDOM_PHASES / 2 - 1) begin
            // One long series whose taps reach back across most of its length,
            // while lags at and past the full depth stay silent. The output
            // side also stalls for a long stretch here.
            idle_on = 1'b1;
            write_mode($urandom_range(0, 1) ? MODE_DIV : MODE_MUL);
            write_lead(RES_W'(rand_residue()));
            write_tap(0, 1, RES_W'(rand_tap_coef()));
            write_tap(1, LONG_LEN / 2, RES_W'(rand_tap_coef()));
            write_tap(2, LONG_LEN - 20, RES_W'(rand_tap_coef()));
            write_tap(3, LONG_LEN - 1, RES_W'($urandom_range(1, MOD_U - 1)));
            write_tap(4, MAX_LAG, RES_W'($urandom_range(1, MOD_U - 1)));
            write_tap(5, MAX_LAG + 1, RES_W'($urandom_range(1, MOD_U - 1)));
            settings_used++;
            for (int i = 0; i < LONG_LEN; i++) begin
               add_word(rand_coefficient(), i == 0);
            end
            hold_armed = 1'b1;
            wait_idle();
         end
      end

      $display("Sent %0d series words under %0d register settings (%0d writes),",
               words_sent, settings_used, csr_writes);
      $display("including one %0d-word series behind a long output stall; %0d results compared.",
               LONG_LEN, results_checked);
      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
